/* rtl/stt_pkg.sv */
package stt_pkg;

  // Character codes that the tokenizer reacts to.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int unsigned DEPTH_W = 4;
  localparam int unsigned LINE_W  = 16;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  // Entries held between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       input_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        token_char;
    logic              char_valid;
    logic              token_end;
    logic              stream_done;
    logic [LINE_W-1:0] line_number;
  } out_item_t;

  // One classified item: an optional close beat ahead of the main beat.
  typedef struct packed {
    logic      pre_close;
    out_item_t res;
  } entry_t;

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_TAB) ||
           (ch == CH_EQUAL) || (ch == CH_COMMA) || (ch == CH_SEMI);
  endfunction

endpackage

/* rtl/scene_text_tokenizer_unit.sv */
// Scene text tokenizer.
// Input channel: one raw byte per beat on in_item, taken when push is high
// and full is low. A beat with input_end set closes the stream.
// Result channel: the oldest result sits on out_item while empty is low and
// leaves on a cycle with pop high. Each result is one token character, a
// token close marker, or the end-of-stream marker, with the line count.
// Results pass from the classifier through the queue into the output register.
// Throughput: one input byte per cycle while full is low. A parenthesis that
// follows an open token gives two results, a close marker and then the
// parenthesis; a four-entry queue between the classifier and the result
// stage absorbs this, and full rises only when that queue is full.
// Bytes inside comments and dropped blanks give no result at all.
// When the receiver stalls, results wait in the output register and the
// queue; once the queue fills, full holds off the sender. Nothing is lost.
// Reset clears the token length, comment depth, blank skip flag, line
// count and all queued results.
module scene_text_tokenizer_unit #(
  parameter int unsigned TOKEN_BUFFER_SIZE   = 64,
  parameter int unsigned MAX_COMMENT_NESTING = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  stt_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output stt_pkg::out_item_t out_item
);
  import stt_pkg::*;

  logic   accept;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_entry, q_head;

  assign full   = q_full;
  assign accept = push && !q_full;

  stt_front #(
    .TOKEN_BUFFER_SIZE  (TOKEN_BUFFER_SIZE),
    .MAX_COMMENT_NESTING(MAX_COMMENT_NESTING)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .q_push (q_push),
    .q_entry(q_entry)
  );

  stt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_data(q_entry),
    .rd_en  (q_pop),
    .rd_data(q_head),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  stt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_item(out_item)
  );

endmodule

/* rtl/stt_front.sv */
module stt_front #(
  parameter int unsigned TOKEN_BUFFER_SIZE   = 64,
  parameter int unsigned MAX_COMMENT_NESTING = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  stt_pkg::in_item_t item,
  output logic              q_push,
  output stt_pkg::entry_t   q_entry
);
  import stt_pkg::*;

  localparam int unsigned LEN_W = $clog2(TOKEN_BUFFER_SIZE);
  localparam logic [LEN_W-1:0]   LEN_LIMIT = LEN_W'(TOKEN_BUFFER_SIZE - 1);
  localparam logic [DEPTH_W-1:0] NEST_MAX  = DEPTH_W'(MAX_COMMENT_NESTING);

  logic [LEN_W-1:0]   len_r, len_nxt, len_inc;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               skip_r, skip_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [7:0]         ch, ch_up;

  assign ch      = item.byte_value;
  assign ch_up   = ((ch >= CH_LOW_A) && (ch <= CH_LOW_Z)) ? (ch - CASE_OFFSET) : ch;
  assign len_inc = len_r + LEN_W'(1);

  // Classify the byte, update the token state and build the queue entry.
  always_comb begin
    len_nxt   = len_r;
    depth_nxt = depth_r;
    skip_nxt  = skip_r;
    line_nxt  = line_r;
    q_push    = 1'b0;
    q_entry   = '0;

    if (!item.input_end && (ch == CH_LF) && (line_r != LINE_MAX)) begin
      line_nxt = line_r + LINE_W'(1);
    end
    q_entry.res.line_number = line_nxt;

    priority if (item.input_end) begin
      q_push                  = 1'b1;
      q_entry.res.token_end   = (len_r != '0);
      q_entry.res.stream_done = 1'b1;
      len_nxt                 = '0;
      depth_nxt               = '0;
      skip_nxt                = 1'b0;
    end else if (depth_r != '0) begin
      // Inside a comment only braces and newlines change anything.
      if (ch == CH_LBRACE) begin
        if (depth_r < NEST_MAX) begin
          depth_nxt = depth_r + DEPTH_W'(1);
        end
      end else if (ch == CH_RBRACE) begin
        depth_nxt = depth_r - DEPTH_W'(1);
        if (depth_r == DEPTH_W'(1)) begin
          skip_nxt = 1'b1;
        end
      end
    end else if (is_blank(ch)) begin
      if (!skip_r && (len_r != '0)) begin
        q_push                = 1'b1;
        q_entry.res.token_end = 1'b1;
        len_nxt               = '0;
      end
    end else begin
      skip_nxt = 1'b0;
      if (ch_up == CH_LBRACE) begin
        depth_nxt = DEPTH_W'(1);
      end else if ((ch_up == CH_LPAREN) || (ch_up == CH_RPAREN)) begin
        q_push                 = 1'b1;
        q_entry.pre_close      = (len_r != '0);
        q_entry.res.token_char = ch_up;
        q_entry.res.char_valid = 1'b1;
        q_entry.res.token_end  = 1'b1;
        len_nxt                = '0;
      end else begin
        q_push                 = 1'b1;
        q_entry.res.token_char = ch_up;
        q_entry.res.char_valid = 1'b1;
        if (len_inc >= LEN_LIMIT) begin
          q_entry.res.token_end = 1'b1;
          len_nxt               = '0;
        end else begin
          len_nxt = len_inc;
        end
      end
    end

    if (!accept) begin
      q_push = 1'b0;
    end
  end

  // Token state advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      depth_r <= '0;
      skip_r  <= 1'b0;
      line_r  <= '0;
    end else if (accept) begin
      len_r   <= len_nxt;
      depth_r <= depth_nxt;
      skip_r  <= skip_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

/* rtl/stt_queue.sv */
module stt_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  stt_pkg::entry_t wr_data,
  input  logic            rd_en,
  output stt_pkg::entry_t rd_data,
  output logic            q_full,
  output logic            q_empty
);
  import stt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CNT_FULL);
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/stt_back.sv */
module stt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  stt_pkg::entry_t    q_head,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output stt_pkg::out_item_t out_item
);
  import stt_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      phase_r, phase_nxt;
  logic      load;

  assign empty    = !out_valid_r;
  assign out_item = out_data_r;
  assign load     = !q_empty && (!out_valid_r || pop);

  // Expand the head entry into one or two beats for the output register.
  always_comb begin
    out_data_nxt  = out_data_r;
    phase_nxt     = phase_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (q_head.pre_close && !phase_r) begin
        out_data_nxt             = '0;
        out_data_nxt.token_end   = 1'b1;
        out_data_nxt.line_number = q_head.res.line_number;
        phase_nxt                = 1'b1;
      end else begin
        out_data_nxt = q_head.res;
        phase_nxt    = 1'b0;
        q_pop        = 1'b1;
      end
    end else if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

/* bench/tb_scene_text_tokenizer_unit.sv */
`timescale 1ns / 100ps

module tb_scene_text_tokenizer_unit;
  import stt_pkg::*;

  localparam int unsigned TOKEN_LIMIT = 64;
  localparam int unsigned NEST_LIMIT  = 15;
  // Cycles with no beat on either side before the run is declared hung.
  // The longest legal quiet spell is a random idle streak on one side plus
  // the drain at the end, which is far below this.
  localparam int unsigned HANG_LIMIT  = 2000;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  // Shadow state of the tokenizer.
  logic [6:0]        tok_len;
  logic [3:0]        cmt_depth;
  logic              skip_after_cmt;
  logic [LINE_W-1:0] lines_seen;

  // Beats produced by the most recent byte, and the beats still owed.
  out_item_t step_res [2];
  int        step_n;
  out_item_t token_beats_due [$];

  // Directed stimulus rows; n_typed < 0 means the shadow model decides.
  typedef struct {
    in_item_t  stim;
    int        n_typed;
    out_item_t typed0;
    out_item_t typed1;
  } dir_row_t;
  dir_row_t dir_rows [$];

  logic stall_free = 1'b0;
  int   mismatches = 0;
  int   beats_in = 0;
  int   beats_out = 0;
  int   limit_closes = 0;
  int   deepest_cmt = 0;
  int   ends_seen = 0;
  int   idle_cycles = 0;
  logic [LINE_W-1:0] top_line = '0;

  scene_text_tokenizer_unit #(
    .TOKEN_BUFFER_SIZE  (TOKEN_LIMIT),
    .MAX_COMMENT_NESTING(NEST_LIMIT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  always #10 clk = ~clk;

  function automatic logic is_separator(input logic [7:0] c);
    return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_EQUAL ||
           c == CH_COMMA || c == CH_SEMI;
  endfunction

  function automatic in_item_t mk_byte(input logic [7:0] b, input logic fin);
    in_item_t it;
    it.byte_value = b;
    it.input_end  = fin;
    return it;
  endfunction

  function automatic out_item_t mk_res(input logic [7:0] c, input logic v,
                                       input logic e, input logic d,
                                       input logic [LINE_W-1:0] ln);
    out_item_t r;
    r.token_char  = c;
    r.char_valid  = v;
    r.token_end   = e;
    r.stream_done = d;
    r.line_number = ln;
    return r;
  endfunction

  task automatic add_step_beat(input logic [7:0] c, input logic v, input logic e,
                               input logic d);
    step_res[step_n] = mk_res(c, v, e, d, lines_seen);
    step_n++;
  endtask

  // Shadow tokenizer: advances the state by one byte and fills step_res.
  task automatic tokenize_byte(input in_item_t it);
    logic [7:0] ch;
    ch = it.byte_value;
    step_n = 0;
    if (it.input_end) begin
      add_step_beat(8'h00, 1'b0, tok_len != 0, 1'b1);
      tok_len = '0;
      cmt_depth = '0;
      skip_after_cmt = 1'b0;
      return;
    end
    if (ch == CH_LF && lines_seen != LINE_MAX) lines_seen++;
    // Inside a comment only braces and newlines matter.
    if (cmt_depth != 0) begin
      if (ch == CH_LBRACE) begin
        if (cmt_depth < NEST_LIMIT) cmt_depth++;
        if (cmt_depth > deepest_cmt) deepest_cmt = cmt_depth;
      end else if (ch == CH_RBRACE) begin
        cmt_depth--;
        if (cmt_depth == 0) skip_after_cmt = 1'b1;
      end
      return;
    end
    if (is_separator(ch)) begin
      if (!skip_after_cmt && tok_len != 0) begin
        add_step_beat(8'h00, 1'b0, 1'b1, 1'b0);
        tok_len = '0;
      end
      return;
    end
    skip_after_cmt = 1'b0;
    if (ch >= CH_LOW_A && ch <= CH_LOW_Z) ch = ch - CASE_OFFSET;
    if (ch == CH_LBRACE) begin
      cmt_depth = 1;
      return;
    end
    // Parentheses stand alone, closing any open token first.
    if (ch == CH_LPAREN || ch == CH_RPAREN) begin
      if (tok_len != 0) add_step_beat(8'h00, 1'b0, 1'b1, 1'b0);
      add_step_beat(ch, 1'b1, 1'b1, 1'b0);
      tok_len = '0;
      return;
    end
    tok_len++;
    if (tok_len >= TOKEN_LIMIT - 1) begin
      add_step_beat(ch, 1'b1, 1'b1, 1'b0);
      tok_len = '0;
      limit_closes++;
    end else begin
      add_step_beat(ch, 1'b1, 1'b0, 1'b0);
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Compare one received beat with the oldest owed beat.
  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (token_beats_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat %h", got));
      return;
    end
    want = token_beats_due.pop_front();
    if (got.token_char !== want.token_char)
      flag_mismatch($sformatf("token_char %h, want %h", got.token_char, want.token_char));
    if (got.char_valid !== want.char_valid)
      flag_mismatch($sformatf("char_valid %b, want %b", got.char_valid, want.char_valid));
    if (got.token_end !== want.token_end)
      flag_mismatch($sformatf("token_end %b, want %b", got.token_end, want.token_end));
    if (got.stream_done !== want.stream_done)
      flag_mismatch($sformatf("stream_done %b, want %b", got.stream_done,
                              want.stream_done));
    if (got.line_number !== want.line_number)
      flag_mismatch($sformatf("line_number %0d, want %0d", got.line_number,
                              want.line_number));
  endtask

  // Offer one byte beat, with random gaps ahead of it, and book its results.
  task automatic send_beat(input in_item_t it, input int n_typed,
                           input out_item_t t0, input out_item_t t1);
    while (!stall_free && $urandom_range(0, 99) < 36) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    tokenize_byte(it);
    if (n_typed < 0) begin
      for (int i = 0; i < step_n; i++) token_beats_due.push_back(step_res[i]);
    end else begin
      if (n_typed > 0) token_beats_due.push_back(t0);
      if (n_typed > 1) token_beats_due.push_back(t1);
    end
    beats_in++;
  endtask

  task automatic send_char(input logic [7:0] b);
    send_beat(mk_byte(b, 1'b0), -1, '0, '0);
  endtask

  // Hold the sender off until every owed beat has come back.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (token_beats_due.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [7:0] b, input logic fin, input int n_typed,
                         input out_item_t t0, input out_item_t t1);
    dir_row_t row;
    row.stim    = mk_byte(b, fin);
    row.n_typed = n_typed;
    row.typed0  = t0;
    row.typed1  = t1;
    dir_rows.push_back(row);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = CH_LOW_A + 8'($urandom_range(0, 25));
      1: c = CH_LOW_A - CASE_OFFSET + 8'($urandom_range(0, 25));
      2: c = 8'h30 + 8'($urandom_range(0, 9));
      default: begin
        c = 8'($urandom_range(0, 255));
        if (is_separator(c) || c == CH_LBRACE || c == CH_LPAREN || c == CH_RPAREN)
          c = 8'h2E;
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_LF;
      2: return CH_TAB;
      3: return CH_EQUAL;
      4: return CH_COMMA;
      default: return CH_SEMI;
    endcase
  endfunction

  // One random piece of scene text: mostly well-formed, some noise.
  task automatic emit_segment();
    int kind;
    int len;
    int opens;
    int closes;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(56, 70) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_char(word_char());
    end else if (kind < 58) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) send_char(blank_char());
    end else if (kind < 68) begin
      send_char($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
    end else if (kind < 80) begin
      // Nested comment, sometimes deeper than the depth counter can hold,
      // and sometimes left open.
      opens = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 3);
      for (int i = 0; i < opens; i++) send_char(CH_LBRACE);
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_LBRACE || c == CH_RBRACE) c = CH_LF;
        send_char(c);
      end
      closes = (opens > NEST_LIMIT) ? NEST_LIMIT : opens;
      if ($urandom_range(0, 9) == 0) closes = $urandom_range(0, closes);
      for (int i = 0; i < closes; i++) send_char(CH_RBRACE);
    end else if (kind < 84) begin
      send_beat(mk_byte(8'($urandom_range(0, 255)), 1'b1), -1, '0, '0);
    end else begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
        send_beat(mk_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0),
                  -1, '0, '0);
    end
  endtask

  task automatic run_random(input int target);
    while (beats_in < target) emit_segment();
  endtask

  // Result side: take beats with random stalls and check each one.
  initial begin : result_side
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        check_beat(out_item);
        beats_out++;
        if (out_item.stream_done) ends_seen++;
        if (out_item.line_number > top_line) top_line = out_item.line_number;
      end
      if (!rst_n) pop <= 1'b0;
      else pop <= stall_free || $urandom_range(0, 99) >= 36;
    end
  end

  // Hang detection: no beat on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", HANG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    tok_len = '0;
    cmt_depth = '0;
    skip_after_cmt = 1'b0;
    lines_seen = '0;

    // Rows whose results follow at a glance from the reset state.
    add_row(CH_LOW_A, 1'b0, 1, mk_res(CH_LOW_A - CASE_OFFSET, 1'b1, 1'b0, 1'b0, 16'd0), '0);
    add_row(8'hFF, 1'b0, 1, mk_res(8'hFF, 1'b1, 1'b0, 1'b0, 16'd0), '0);
    add_row(CH_SPACE, 1'b0, 1, mk_res(8'h00, 1'b0, 1'b1, 1'b0, 16'd0), '0);
    add_row(CH_LF, 1'b0, 0, '0, '0);
    add_row(CH_LPAREN, 1'b0, 1, mk_res(CH_LPAREN, 1'b1, 1'b1, 1'b0, 16'd1), '0);
    // Case folding, paren after an open token, zero byte.
    add_row(CH_LOW_Z, 1'b0, -1, '0, '0);
    add_row(CH_RPAREN, 1'b0, -1, '0, '0);
    add_row(8'h00, 1'b0, -1, '0, '0);
    // Nested comment with a newline and text inside it.
    add_row(CH_LBRACE, 1'b0, -1, '0, '0);
    add_row(CH_LBRACE, 1'b0, -1, '0, '0);
    add_row(CH_LF, 1'b0, -1, '0, '0);
    add_row(8'h71, 1'b0, -1, '0, '0);
    add_row(CH_RBRACE, 1'b0, -1, '0, '0);
    add_row(CH_RBRACE, 1'b0, -1, '0, '0);
    // Blanks skipped after the comment, then the token goes on.
    add_row(CH_TAB, 1'b0, -1, '0, '0);
    add_row(CH_EQUAL, 1'b0, -1, '0, '0);
    add_row(8'h42, 1'b0, -1, '0, '0);
    // A stray closing brace is a plain character.
    add_row(CH_RBRACE, 1'b0, -1, '0, '0);
    add_row(CH_COMMA, 1'b0, -1, '0, '0);
    add_row(CH_SEMI, 1'b0, -1, '0, '0);
    // End of input with and without an open token.
    add_row(8'hAA, 1'b1, -1, '0, '0);
    add_row(8'h78, 1'b0, -1, '0, '0);
    add_row(8'hFF, 1'b1, -1, '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].stim, dir_rows[i].n_typed, dir_rows[i].typed0,
                dir_rows[i].typed1);

    run_random(375);

    // Let everything come back before sending more.
    drain_results();

    // A stretch with neither side idling, then random idling again.
    stall_free = 1'b1;
    run_random(525);
    stall_free = 1'b0;
    run_random(750);
    send_beat(mk_byte(8'h00, 1'b1), -1, '0, '0);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d input beats and %0d result beats: %0d stream ends,",
             beats_in, beats_out, ends_seen);
    $display("%0d size-limit closes, comment depth up to %0d, line count up to %0d.",
             limit_closes, deepest_cmt, top_line);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* scene_text_tokenizer_unit.f */
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/scene_text_tokenizer_unit.sv
bench/tb_scene_text_tokenizer_unit.sv
